[sv/jet_pkg.sv]
`timescale 1ns / 1ps

package jet_pkg;

    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned MAX_DIM   = 2048;

    localparam int unsigned PIX_W   = 11;
    localparam int unsigned ITER_W  = 12;
    localparam int unsigned STEP_W  = 31;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned MUL_W   = COORD_W + 1;
    localparam int unsigned PROD_W  = 2 * MUL_W;
    localparam int unsigned CFG_W   = 3;
    localparam int unsigned DIM_W   = 14;

    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP = 31'd2684354;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN     = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_JULIA      = 32'sd0;
    localparam logic [ITER_W-1:0]         RST_MAX_ITER   = 12'd100;

    typedef enum logic [CFG_W-1:0] {
        CFG_PIXEL_STEP = 3'd0,
        CFG_ORIGIN_RE  = 3'd1,
        CFG_ORIGIN_IM  = 3'd2,
        CFG_JULIA_RE   = 3'd3,
        CFG_JULIA_IM   = 3'd4,
        CFG_MAX_ITER   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_MY,
        S_AY,
        S_LOOP,
        S_SQI,
        S_CRS,
        S_ESC,
        S_UPD
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [ITER_W-1:0] iter_count;
        logic              inside_res;
    } t_result;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // floor shift of a product, then clamp to the coordinate range
    function automatic logic signed [COORD_W-1:0] shr_sat(input logic signed [PROD_W-1:0] p,
                                                          input int unsigned s);
        return sat32(p >>> s);
    endfunction

endpackage

[sv/jet_mul.sv]
`timescale 1ns / 1ps

module jet_mul (
    input  logic                               i_clk,
    input  logic signed [jet_pkg::MUL_W-1:0]   i_a,
    input  logic signed [jet_pkg::MUL_W-1:0]   i_b,
    output logic signed [jet_pkg::PROD_W-1:0]  o_prod
);

    logic signed [jet_pkg::PROD_W-1:0] r_prod;
    logic signed [jet_pkg::PROD_W-1:0] n_prod;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

[sv/julia_escape_time.sv]
`timescale 1ns / 1ps

// Julia-set escape-time unit. Pulse start with a pixel while busy is low; the
// word is taken at that edge and busy rises until the result is out. Every
// multiplication runs on one 33x33 signed multiplier with a registered
// product, stepped by a small sequencer, so the multiplier sets the pace.
// Pixel indexes at or above MAX_DIM are folded in S_REDUCE (only possible
// when MAX_DIM is below 2048, never by default); setup runs through S_REDUCE,
// S_MY and S_AY, each iteration through S_LOOP, S_SQI, S_CRS, S_ESC and S_UPD,
// and the unit finishes in S_LOOP (limit reached) or S_ESC (escape). The result
// appears on o_result for exactly one cycle with o_done high and cannot be
// stalled, so the receiver must take it then. A new pixel may be started in the
// same cycle the result is shown. The configuration port is always ready; write it only while the unit is idle.
module julia_escape_time #(
    parameter int unsigned MAX_DIM   = jet_pkg::MAX_DIM,
    parameter int unsigned FRAC_BITS = jet_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  jet_pkg::t_pixel               i_pixel,
    output logic                          o_done,
    output jet_pkg::t_result              o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [jet_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [jet_pkg::COORD_W-1:0]   i_cfg_data
);

    // 4.0 in the coordinate format
    localparam logic signed [jet_pkg::PROD_W-1:0] ESC_LIMIT =
        jet_pkg::PROD_W'(4) <<< FRAC_BITS;

    // configuration
    logic [jet_pkg::STEP_W-1:0]          r_pixel_step;
    logic signed [jet_pkg::COORD_W-1:0]  r_origin_re;
    logic signed [jet_pkg::COORD_W-1:0]  r_origin_im;
    logic signed [jet_pkg::COORD_W-1:0]  r_julia_re;
    logic signed [jet_pkg::COORD_W-1:0]  r_julia_im;
    logic [jet_pkg::ITER_W-1:0]          r_max_iter;

    // sequencer and datapath
    jet_pkg::t_state                     r_state, n_state;
    logic [jet_pkg::PIX_W-1:0]           r_px, n_px;
    logic [jet_pkg::PIX_W-1:0]           r_py, n_py;
    logic signed [jet_pkg::COORD_W-1:0]  r_zr, n_zr;
    logic signed [jet_pkg::COORD_W-1:0]  r_zi, n_zi;
    logic signed [jet_pkg::COORD_W-1:0]  r_zr2, n_zr2;
    logic signed [jet_pkg::COORD_W-1:0]  r_zi2, n_zi2;
    logic signed [jet_pkg::COORD_W-1:0]  r_diff, n_diff;
    logic [jet_pkg::ITER_W-1:0]          r_count, n_count;
    logic                                r_done, n_done;
    jet_pkg::t_result                    r_res, n_res;

    logic signed [jet_pkg::MUL_W-1:0]    mul_a, mul_b;
    logic signed [jet_pkg::PROD_W-1:0]   prod;
    logic signed [jet_pkg::MUL_W-1:0]    step_op;
    logic [jet_pkg::DIM_W-1:0]           dim_c;
    logic                                px_hi, py_hi;
    logic                                iter_end;
    logic                                escape;

    assign dim_c    = jet_pkg::DIM_W'(MAX_DIM);
    assign px_hi    = jet_pkg::DIM_W'(r_px) >= dim_c;
    assign py_hi    = jet_pkg::DIM_W'(r_py) >= dim_c;
    assign step_op  = $signed({2'b00, r_pixel_step});
    assign iter_end = r_count >= r_max_iter;
    assign escape   = (jet_pkg::PROD_W'(r_zr2) + jet_pkg::PROD_W'(r_zi2)) >= ESC_LIMIT;

    jet_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jet_pkg::S_IDLE: begin
                if (start) n_state = jet_pkg::S_REDUCE;
            end
            jet_pkg::S_REDUCE: begin
                if (!px_hi && !py_hi) n_state = jet_pkg::S_MY;
            end
            jet_pkg::S_MY:  n_state = jet_pkg::S_AY;
            jet_pkg::S_AY:  n_state = jet_pkg::S_LOOP;
            jet_pkg::S_LOOP: begin
                n_state = iter_end ? jet_pkg::S_IDLE : jet_pkg::S_SQI;
            end
            jet_pkg::S_SQI: n_state = jet_pkg::S_CRS;
            jet_pkg::S_CRS: n_state = jet_pkg::S_ESC;
            jet_pkg::S_ESC: begin
                n_state = escape ? jet_pkg::S_IDLE : jet_pkg::S_UPD;
            end
            jet_pkg::S_UPD: n_state = jet_pkg::S_LOOP;
            default:        n_state = jet_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_px    = r_px;
        n_py    = r_py;
        n_zr    = r_zr;
        n_zi    = r_zi;
        n_zr2   = r_zr2;
        n_zi2   = r_zi2;
        n_diff  = r_diff;
        n_count = r_count;
        n_done  = 1'b0;
        n_res   = r_res;
        mul_a   = jet_pkg::MUL_W'(r_zr);
        mul_b   = jet_pkg::MUL_W'(r_zr);
        case (r_state)
            jet_pkg::S_IDLE: begin
                if (start) begin
                    n_px    = i_pixel.pixel_x;
                    n_py    = i_pixel.pixel_y;
                    n_count = '0;
                end
            end
            jet_pkg::S_REDUCE: begin
                // fold indices into the frame, then scale x
                if (px_hi) n_px = jet_pkg::PIX_W'(jet_pkg::DIM_W'(r_px) - dim_c);
                if (py_hi) n_py = jet_pkg::PIX_W'(jet_pkg::DIM_W'(r_py) - dim_c);
                mul_a = $signed({{(jet_pkg::MUL_W - jet_pkg::PIX_W){1'b0}}, r_px});
                mul_b = step_op;
            end
            jet_pkg::S_MY: begin
                n_zr  = jet_pkg::sat32(prod + jet_pkg::PROD_W'(r_origin_re));
                mul_a = $signed({{(jet_pkg::MUL_W - jet_pkg::PIX_W){1'b0}}, r_py});
                mul_b = step_op;
            end
            jet_pkg::S_AY: begin
                n_zi = jet_pkg::sat32(prod + jet_pkg::PROD_W'(r_origin_im));
            end
            jet_pkg::S_LOOP: begin
                if (iter_end) begin
                    n_done           = 1'b1;
                    n_res.iter_count = r_count;
                    n_res.inside_res = (r_count == r_max_iter);
                end
            end
            jet_pkg::S_SQI: begin
                n_zr2 = jet_pkg::shr_sat(prod, FRAC_BITS);
                mul_a = jet_pkg::MUL_W'(r_zi);
                mul_b = jet_pkg::MUL_W'(r_zi);
            end
            jet_pkg::S_CRS: begin
                n_zi2 = jet_pkg::shr_sat(prod, FRAC_BITS);
                mul_a = jet_pkg::MUL_W'(r_zr);
                mul_b = jet_pkg::MUL_W'(r_zi);
            end
            jet_pkg::S_ESC: begin
                if (escape) begin
                    n_done           = 1'b1;
                    n_res.iter_count = r_count;
                    n_res.inside_res = (r_count == r_max_iter);
                end else begin
                    n_diff = jet_pkg::sat32(jet_pkg::PROD_W'(r_zr2) - jet_pkg::PROD_W'(r_zi2));
                    // one shift less doubles the cross product
                    n_zi   = jet_pkg::sat32(
                        jet_pkg::PROD_W'(jet_pkg::shr_sat(prod, FRAC_BITS - 1))
                        + jet_pkg::PROD_W'(r_julia_im));
                end
            end
            jet_pkg::S_UPD: begin
                n_zr    = jet_pkg::sat32(jet_pkg::PROD_W'(r_diff) + jet_pkg::PROD_W'(r_julia_re));
                n_count = r_count + 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jet_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_zr2   <= n_zr2;
        r_zi2   <= n_zi2;
        r_diff  <= n_diff;
        r_count <= n_count;
        r_res   <= n_res;
    end

    // configuration registers; unknown indexes drop the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_step <= jet_pkg::RST_PIXEL_STEP;
            r_origin_re  <= jet_pkg::RST_ORIGIN;
            r_origin_im  <= jet_pkg::RST_ORIGIN;
            r_julia_re   <= jet_pkg::RST_JULIA;
            r_julia_im   <= jet_pkg::RST_JULIA;
            r_max_iter   <= jet_pkg::RST_MAX_ITER;
        end else if (i_cfg_valid) begin
            case (jet_pkg::t_cfg_idx'(i_cfg_index))
                jet_pkg::CFG_PIXEL_STEP: r_pixel_step <= i_cfg_data[jet_pkg::STEP_W-1:0];
                jet_pkg::CFG_ORIGIN_RE:  r_origin_re  <= $signed(i_cfg_data);
                jet_pkg::CFG_ORIGIN_IM:  r_origin_im  <= $signed(i_cfg_data);
                jet_pkg::CFG_JULIA_RE:   r_julia_re   <= $signed(i_cfg_data);
                jet_pkg::CFG_JULIA_IM:   r_julia_im   <= $signed(i_cfg_data);
                jet_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[jet_pkg::ITER_W-1:0];
                default: begin
                    r_max_iter <= r_max_iter;
                end
            endcase
        end
    end

    assign busy        = (r_state != jet_pkg::S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted pixel did not raise busy");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == jet_pkg::S_LOOP || $past(r_state) == jet_pkg::S_ESC))
        else $error("result strobe without loop exit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jet_pkg::S_UPD) |=> (r_count == jet_pkg::ITER_W'($past(r_count) + 1'b1)))
        else $error("iteration count did not advance");
`endif

endmodule
